// File: rtl/sitda_pkg.sv
package sitda_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int BITS_PER_STAGE  = 4;
    localparam logic [7:0] DIGIT_BASE = 8'd48;
    localparam logic [7:0] MINUS_CODE = 8'd45;

    // decimal digits needed for the largest magnitude, 2^(w-1)
    function automatic int dec_digits(input int w);
        longint unsigned m;
        int n;
        m = 64'd1 << (w - 1);
        n = 0;
        while (m != 64'd0)
        begin
            m = m / 64'd10;
            n = n + 1;
        end
        return n;
    endfunction

endpackage

// File: rtl/sitda_in_if.sv
interface sitda_in_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// File: rtl/sitda_out_if.sv
interface sitda_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// File: rtl/sitda_bcd_pipe.sv
module sitda_bcd_pipe #(
    parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   enable,
    input  logic                                                   in_valid,
    input  logic [VALUE_WIDTH-1:0]                                 in_value,
    output logic                                                   out_valid,
    output logic                                                   out_neg,
    output logic [sitda_pkg::dec_digits(VALUE_WIDTH)*4-1:0]        out_bcd
);
    import sitda_pkg::*;

    localparam int NDIG   = dec_digits(VALUE_WIDTH);
    localparam int BCD_W  = NDIG * 4;
    localparam int STAGES = (VALUE_WIDTH + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int PAD_W  = STAGES * BITS_PER_STAGE;

    logic             vld_reg [0:STAGES];
    logic             neg_reg [0:STAGES];
    logic [BCD_W-1:0] bcd_reg [0:STAGES];
    logic [PAD_W-1:0] bin_reg [0:STAGES];

    // one double dabble step: add 3 to digits of 5 or more, then shift in a bit
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd, input logic b);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int d = 0; d < NDIG; d++)
        begin
            if (bcd[d*4 +: 4] >= 4'd5)
            begin
                adj[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], b};
    endfunction

    logic [VALUE_WIDTH-1:0] mag;
    assign mag = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (enable)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            neg_reg[0] <= in_value[VALUE_WIDTH-1];
            bcd_reg[0] <= '0;
            bin_reg[0] <= PAD_W'(mag);
        end
    end

    for (genvar s = 1; s <= STAGES; s++)
    begin : g_stage
        logic [BCD_W-1:0] bcd_next;
        logic [PAD_W-1:0] bin_next;

        always_comb
        begin
            bcd_next = bcd_reg[s-1];
            bin_next = bin_reg[s-1];
            for (int k = 0; k < BITS_PER_STAGE; k++)
            begin
                bcd_next = dabble(bcd_next, bin_next[PAD_W-1]);
                bin_next = {bin_next[PAD_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (enable)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (enable)
            begin
                neg_reg[s] <= neg_reg[s-1];
                bcd_reg[s] <= bcd_next;
                bin_reg[s] <= bin_next;
            end
        end
    end

    assign out_valid = vld_reg[STAGES];
    assign out_neg   = neg_reg[STAGES];
    assign out_bcd   = bcd_reg[STAGES];

endmodule

// File: rtl/sitda_ser.sv
module sitda_ser #(
    parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            in_valid,
    output logic                                            in_ready,
    input  logic                                            in_neg,
    input  logic [sitda_pkg::dec_digits(VALUE_WIDTH)*4-1:0] in_bcd,
    sitda_out_if.source                                     out_word
);
    import sitda_pkg::*;

    localparam int NDIG  = dec_digits(VALUE_WIDTH);
    localparam int IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;

    logic             busy_reg, busy_next;
    logic             minus_reg, minus_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [3:0]       dig_reg [NDIG];
    logic             ovld_reg, ovld_next;
    logic [7:0]       code_reg, code_next;
    logic             last_reg, last_next;

    logic             out_free;
    logic             finishing;
    logic             load;
    logic [IDX_W-1:0] lead;
    logic [3:0]       cur_dig;

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            if (in_bcd[i*4 +: 4] != 4'd0)
            begin
                lead = IDX_W'(i);
            end
        end
    end

    assign cur_dig   = dig_reg[idx_reg];
    assign out_free  = !ovld_reg || out_word.ready;
    assign finishing = busy_reg && out_free && !minus_reg && (idx_reg == '0);
    assign in_ready  = !busy_reg || finishing;
    assign load      = in_valid && in_ready;

    always_comb
    begin
        busy_next  = busy_reg;
        minus_next = minus_reg;
        idx_next   = idx_reg;
        ovld_next  = ovld_reg;
        code_next  = code_reg;
        last_next  = last_reg;
        if (out_free)
        begin
            ovld_next = busy_reg;
            if (busy_reg)
            begin
                if (minus_reg)
                begin
                    code_next  = MINUS_CODE;
                    last_next  = 1'b0;
                    minus_next = 1'b0;
                end
                else
                begin
                    code_next = DIGIT_BASE + {4'd0, cur_dig};
                    last_next = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
        end
        if (load)
        begin
            busy_next  = 1'b1;
            minus_next = in_neg;
            idx_next   = lead;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ovld_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            ovld_reg <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        minus_reg <= minus_next;
        idx_reg   <= idx_next;
        code_reg  <= code_next;
        last_reg  <= last_next;
        if (load)
        begin
            for (int i = 0; i < NDIG; i++)
            begin
                dig_reg[i] <= in_bcd[i*4 +: 4];
            end
        end
    end

    assign out_word.valid     = ovld_reg;
    assign out_word.char_code = code_reg;
    assign out_word.last_char = last_reg;

endmodule

// File: rtl/signed_int_to_decimal_ascii_top.sv
// Path from an accepted word to its first character: sign/negate register, double dabble stages
// of 4 bits each, serializer.
// Throughput: one character per cycle while out_word.ready is high, set by the output serializer;
// a number is 1 to 11 characters at 32 bits (digit count plus one for a minus sign).
// Reset: rst_n asynchronous, active low, clears all valid and busy flags.
module signed_int_to_decimal_ascii_top #(
    parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sitda_in_if.sink    in_word,
    sitda_out_if.source out_word
);
    import sitda_pkg::*;

    localparam int NDIG = dec_digits(VALUE_WIDTH);

    logic              enable;
    logic              pipe_valid;
    logic              pipe_neg;
    logic [NDIG*4-1:0] pipe_bcd;

    assign in_word.ready = enable;

    sitda_bcd_pipe #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (enable),
        .in_valid  (in_word.valid),
        .in_value  (in_word.value),
        .out_valid (pipe_valid),
        .out_neg   (pipe_neg),
        .out_bcd   (pipe_bcd)
    );

    sitda_ser #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pipe_valid),
        .in_ready (enable),
        .in_neg   (pipe_neg),
        .in_bcd   (pipe_bcd),
        .out_word (out_word)
    );

endmodule

// File: rtl/sitda_chk.sv
module sitda_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] char_code,
    input logic       last_char
);
    import sitda_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(char_code) && $stable(last_char))
        else $error("output word changed while stalled");

    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (char_code == MINUS_CODE) ||
                      (char_code >= DIGIT_BASE && char_code <= DIGIT_BASE + 8'd9))
        else $error("character outside minus and digits");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (char_code == MINUS_CODE) |-> !last_char)
        else $error("minus sign flagged as last character");

endmodule

bind signed_int_to_decimal_ascii_top sitda_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_word.valid),
    .out_ready (out_word.ready),
    .char_code (out_word.char_code),
    .last_char (out_word.last_char)
);

// File: test/signed_int_to_decimal_ascii_top_tb.sv
module signed_int_to_decimal_ascii_top_tb;

    import sitda_pkg::*;

    localparam int VW          = VALUE_WIDTH_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 3 + (VW + 3) / 4 + 16;

    typedef logic signed [VW-1:0] num_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } char_t;

    logic clk = 1'b0;
    logic rst_n;

    sitda_in_if #(.VALUE_WIDTH(VW)) in_word ();
    sitda_out_if                    out_word ();

    signed_int_to_decimal_ascii_top #(
        .VALUE_WIDTH(VW)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_word),
        .out_word (out_word)
    );

    num_t  numbers_to_send [$];
    char_t pending_chars [$];

    int send_idle_pct = 0;
    int take_idle_pct = 0;
    int mismatch_count = 0;
    int numbers_sent = 0;
    int negatives_sent = 0;
    int chars_checked = 0;
    int stall_cycles;

    int directed_values [0:19] = '{
        0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
        32'h7fffffff, 32'h80000000, 32'h80000001, 1000000000, 999999999,
        -999999999, 1234567890, -1234567890, 32'h55555555, 32'haaaaaaaa
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // decimal text of one number: optional minus, then digits msb first
    function automatic void spell_number(input num_t v);
        logic [VW:0] mag;
        logic [3:0]  digit_buf [0:19];
        int          n;
        char_t       c;
        if (v[VW-1])
        begin
            mag = {(VW+1){1'b0}} - {v[VW-1], v};
            negatives_sent++;
            c.char_code = MINUS_CODE;
            c.last_char = 1'b0;
            pending_chars.push_back(c);
        end
        else
        begin
            mag = {1'b0, v};
        end
        n = 0;
        do
        begin
            digit_buf[n] = 4'(mag % 10);
            mag = mag / 10;
            n++;
        end
        while (mag != 0);
        for (int i = n - 1; i >= 0; i--)
        begin
            c.char_code = DIGIT_BASE + 8'(digit_buf[i]);
            c.last_char = (i == 0);
            pending_chars.push_back(c);
        end
        numbers_sent++;
    endfunction

    function automatic num_t pick_number();
        num_t v;
        int   p;
        case ($urandom_range(3))
            0: v = num_t'($urandom());
            1: v = num_t'($urandom_range(0, 999));
            2:
            begin
                p = 1;
                repeat ($urandom_range(0, 9)) p = p * 10;
                v = num_t'(p + $urandom_range(0, 2) - 1);
            end
            default: v = num_t'($urandom() >> $urandom_range(0, 31));
        endcase
        if ($urandom_range(1))
            v = -v;
        return v;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_word.valid <= 1'b0;
            in_word.value <= '0;
        end
        else
        begin
            if (in_word.valid && in_word.ready)
                spell_number(in_word.value);
            if (!in_word.valid || in_word.ready)
            begin
                if (numbers_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_word.valid <= 1'b1;
                    in_word.value <= numbers_to_send.pop_front();
                end
                else
                begin
                    in_word.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : take_chars
        char_t want;
        if (!rst_n)
        begin
            out_word.ready <= 1'b0;
        end
        else
        begin
            if (out_word.valid && out_word.ready)
            begin
                chars_checked++;
                if (pending_chars.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected char 0x%02h last %b",
                        out_word.char_code, out_word.last_char));
                end
                else
                begin
                    want = pending_chars.pop_front();
                    if (out_word.char_code !== want.char_code)
                        report_mismatch($sformatf("char_code 0x%02h, want 0x%02h",
                            out_word.char_code, want.char_code));
                    if (out_word.last_char !== want.last_char)
                        report_mismatch($sformatf("last_char %b, want %b",
                            out_word.last_char, want.last_char));
                end
            end
            out_word.ready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_cycles <= 0;
        end
        else if ((in_word.valid && in_word.ready) || (out_word.valid && out_word.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("signed_int_to_decimal_ascii_top_tb: done, errors");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // sender holds back until every expected char is out
    task automatic drain();
        while (numbers_to_send.size() != 0 || in_word.valid || pending_chars.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int send_pct, input int take_pct, input int n_random,
                             input bit with_directed);
        send_idle_pct = send_pct;
        take_idle_pct = take_pct;
        @(negedge clk);
        if (with_directed)
            foreach (directed_values[i])
                numbers_to_send.push_back(num_t'(directed_values[i]));
        repeat (n_random) numbers_to_send.push_back(pick_number());
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_phase(35, 59, 40, 1'b1);
        run_phase(59, 35, 60, 1'b0);
        run_phase(0, 0, 60, 1'b0);

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("converted %0d numbers (%0d negative), incl. zero and both 32-bit extremes",
            numbers_sent, negatives_sent);
        $display("checked %0d chars under sender/receiver backpressure and full rate",
            chars_checked);
        if (mismatch_count == 0)
            $display("signed_int_to_decimal_ascii_top_tb: done, clean");
        else
            $display("signed_int_to_decimal_ascii_top_tb: done, errors");
        $finish;
    end

endmodule

// File: sim.f
rtl/sitda_pkg.sv
rtl/sitda_in_if.sv
rtl/sitda_out_if.sv
rtl/sitda_bcd_pipe.sv
rtl/sitda_ser.sv
rtl/signed_int_to_decimal_ascii_top.sv
rtl/sitda_chk.sv
test/signed_int_to_decimal_ascii_top_tb.sv
